// File: hdl/abbp_pkg.sv
package abbp_pkg;

  localparam int DATA_W           = 48;
  localparam int HALF_W           = 24;
  localparam int ACC_W            = 56;
  localparam int VEC_N            = 6;
  localparam int MAX_CLUSTERS_DEF = 64;
  localparam int FRAC_BITS_DEF    = 24;
  localparam int CFG_IDX_W        = 3;

  // per-cluster slot layout in the parameter memory (64 words per cluster)
  localparam int SLOT_W = 6;
  localparam logic [SLOT_W-1:0] OFS_GAIN   = 6'd36;
  localparam logic [SLOT_W-1:0] OFS_BIAS   = 6'd42;
  localparam logic [SLOT_W-1:0] OFS_DRIVE  = 6'd48;
  localparam logic [SLOT_W-1:0] OFS_PARENT = 6'd49;
  localparam int ROW_W = 3;

  localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    FUNC_TRANSFORM,
    FUNC_GAIN,
    FUNC_BIAS,
    FUNC_DRIVE,
    FUNC_PARENT,
    FUNC_ROOT,
    FUNC_RUN,
    FUNC_THERMO
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TH_ON,
    REG_TH_MASS,
    REG_TH_VEL,
    REG_TH_SCALE,
    REG_KE,
    REG_KT
  } cfg_reg_e;

  typedef enum logic {
    KIND_JOINT,
    KIND_THERMO
  } kind_e;

  typedef struct packed {
    logic [2:0]               func;
    logic [5:0]               cluster;
    logic [2:0]               row;
    logic [2:0]               col;
    logic [5:0]               parent;
    logic signed [DATA_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic                     kind;
    logic [5:0]               cluster_res;
    logic signed [DATA_W-1:0] value_res;
  } out_res_t;

  function automatic logic signed [ACC_W-1:0] sx(input logic signed [DATA_W-1:0] x);
    return {{(ACC_W-DATA_W){x[DATA_W-1]}}, x};
  endfunction

  function automatic logic signed [DATA_W-1:0] sat48(input logic signed [ACC_W-1:0] x);
    if (x[ACC_W-1:DATA_W-1] == '0 || x[ACC_W-1:DATA_W-1] == '1) begin
      return x[DATA_W-1:0];
    end
    return x[ACC_W-1] ? SMIN : SMAX;
  endfunction

endpackage

// File: hdl/abbp_ram.sv
module abbp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/abbp_mul.sv
// Q-format multiply: four 24x24 partial products accumulated in turn, then round
// half away from zero and saturate.
module abbp_mul import abbp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] res_o
);

  localparam int PW = 2 * DATA_W;

  logic              busy_q, done_q, neg_q;
  logic [2:0]        step_q;
  logic [DATA_W-1:0] xm_q, ym_q;
  logic [PW-1:0]     acc_q;

  logic [HALF_W-1:0]   xs, ys;
  logic [2*HALF_W-1:0] pp;
  logic [PW-1:0]       pp_sh, rnd, qmag;
  logic [DATA_W-1:0]   am, bm;
  logic signed [DATA_W-1:0] res_sat;

  always_comb begin
    am = a_i[DATA_W-1] ? DATA_W'(-a_i) : DATA_W'(a_i);
    bm = b_i[DATA_W-1] ? DATA_W'(-b_i) : DATA_W'(b_i);
    xs = step_q[1] ? xm_q[DATA_W-1:HALF_W] : xm_q[HALF_W-1:0];
    ys = step_q[0] ? ym_q[DATA_W-1:HALF_W] : ym_q[HALF_W-1:0];
    pp = (2*HALF_W)'(xs) * (2*HALF_W)'(ys);
    case (step_q[1:0])
      2'd0:    pp_sh = PW'(pp);
      2'd1,
      2'd2:    pp_sh = PW'(pp) << HALF_W;
      default: pp_sh = PW'(pp) << DATA_W;
    endcase
    rnd  = acc_q + (PW'(1) << (FRAC_BITS - 1));
    qmag = rnd >> FRAC_BITS;
    if (neg_q) begin
      res_sat = (qmag > (PW'(1) << (DATA_W - 1))) ? SMIN : -$signed(qmag[DATA_W-1:0]);
    end else begin
      res_sat = (qmag > PW'(SMAX)) ? SMAX : $signed(qmag[DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        acc_q  <= '0;
        xm_q   <= am;
        ym_q   <= bm;
        neg_q  <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
      end else if (busy_q) begin
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          res_o  <= res_sat;
        end else begin
          acc_q  <= acc_q + pp_sh;
          step_q <= step_q + 3'd1;
        end
      end
    end
  end

  assign done_o = done_q;

endmodule

// File: hdl/abbp_div.sv
// Q-format divide, one quotient bit per cycle, rounded half away from zero.
module abbp_div import abbp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic [DATA_W-2:0]        d_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] res_o
);

  localparam int NW    = DATA_W + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(NW + 1);

  logic              busy_q, done_q, neg_q;
  logic [NW-1:0]     n_q, q_q;
  logic [DATA_W-2:0] dv_q, rem_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [DATA_W-1:0] xm, rem2, rem_sub;
  logic [NW-1:0]     n0;
  logic              ge;
  logic signed [DATA_W-1:0] res_sat;

  always_comb begin
    xm      = a_i[DATA_W-1] ? DATA_W'(-a_i) : DATA_W'(a_i);
    // dividend pre-shifted, plus half the divisor for rounding
    n0      = (NW'(xm) << FRAC_BITS) + NW'(d_i >> 1);
    rem2    = {rem_q, n_q[NW-1]};
    ge      = rem2 >= {1'b0, dv_q};
    rem_sub = rem2 - {1'b0, dv_q};
    if (neg_q) begin
      res_sat = (q_q > (NW'(1) << (DATA_W - 1))) ? SMIN : -$signed(q_q[DATA_W-1:0]);
    end else begin
      res_sat = (q_q > NW'(SMAX)) ? SMAX : $signed(q_q[DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        neg_q <= a_i[DATA_W-1];
        if (xm == '0) begin
          res_o  <= '0;
          done_q <= 1'b1;
        end else if (d_i == '0) begin
          res_o  <= a_i[DATA_W-1] ? SMIN : SMAX;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          n_q    <= n0;
          q_q    <= '0;
          rem_q  <= '0;
          dv_q   <= d_i;
          cnt_q  <= CNT_W'(NW);
        end
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          rem_q <= ge ? rem_sub[DATA_W-2:0] : rem2[DATA_W-2:0];
          q_q   <= {q_q[NW-2:0], ge};
          n_q   <= n_q << 1;
          cnt_q <= cnt_q - CNT_W'(1);
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          res_o  <= res_sat;
        end
      end
    end
  end

  assign done_o = done_q;

endmodule

// File: hdl/articulated_body_backward_pass.sv
// Load requests and ignored requests are taken in S_IDLE, which stays put. A run
// request does 36 + 6 multiply-accumulates through the shared multiplier, plus a
// divide and a multiply with the thermostat on.
// A thermostat request does two divides and four multiplies. Results wait in an output register.
// Reset: registers to reset values, then zeroing all 8 * MAX_CLUSTERS words of the
// acceleration memory with ready low; configuration writes are taken throughout.
module articulated_body_backward_pass import abbp_pkg::*; #(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_req_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_res_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int CW     = $clog2(MAX_CLUSTERS);
  localparam int PDEPTH = MAX_CLUSTERS * 64;
  localparam int ADEPTH = MAX_CLUSTERS * 8;
  localparam int PAW    = CW + SLOT_W;
  localparam int AAW    = CW + ROW_W;
  localparam logic [63:0] UNIT_Q64 = ((64'd4184070 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic signed [DATA_W-1:0] UNIT_Q = DATA_W'(UNIT_Q64);
  localparam logic [DATA_W-2:0] ONE_Q = (DATA_W-1)'(1) << FRAC_BITS;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_PAR, S_PAR_W,
    S_M_RD, S_M_MUL, S_M_WAIT,
    S_D_RD, S_D_W, S_G_RD, S_G_MUL, S_G_WAIT,
    S_B_RD, S_B_WR,
    S_T_DIV, S_T_DW, S_T_MW,
    S_H_G, S_H_GW, S_H_M1, S_H_M2, S_H_M3, S_H_M4, S_H_D2,
    S_EMIT
  } state_e;

  state_e state_q;
  logic [AAW-1:0] clr_q;
  logic [CW-1:0]  cl_q, par_q;
  logic [2:0]     j_q, k_q;
  logic signed [DATA_W-1:0] val_q, a_q, g_q, t1_q, e_q;
  logic signed [DATA_W-1:0] m_q [VEC_N];
  logic signed [ACC_W-1:0]  acc_q;
  kind_e    kind_q;
  logic     out_valid_q;
  out_res_t out_q;

  logic                     th_on_q;
  logic [DATA_W-2:0]        mass_q, scale_q, ke_q, kt_q;
  logic signed [DATA_W-1:0] vel_q;

  logic              p_we, a_we;
  logic [PAW-1:0]    p_waddr, p_raddr;
  logic [AAW-1:0]    a_waddr, a_raddr;
  logic [DATA_W-1:0] p_wdata, a_wdata, p_rdata, a_rdata;

  logic                     mul_start, mul_done, div_start, div_done;
  logic signed [DATA_W-1:0] mul_a, mul_b, mul_res, div_a, div_res;
  logic [DATA_W-2:0]        div_d;

  logic           in_acc, cl_ok;
  logic [CW-1:0]  cl_in;
  logic [SLOT_W-1:0] ld_ofs;
  logic           ld_ok;
  logic signed [DATA_W-1:0] t_val;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cl_in      = CW'(in_data_i.cluster);
  assign cl_ok      = int'(in_data_i.cluster) < MAX_CLUSTERS;
  assign t_val      = sat48((sx(t1_q) <<< 1) - sx(mul_res));

  // load decode
  always_comb begin
    ld_ok  = 1'b0;
    ld_ofs = '0;
    case (func_e'(in_data_i.func))
      FUNC_TRANSFORM: begin
        ld_ok  = cl_ok && in_data_i.row < 3'(VEC_N) && in_data_i.col < 3'(VEC_N);
        ld_ofs = ({3'b0, in_data_i.row} * 6'd6) + {3'b0, in_data_i.col};
      end
      FUNC_GAIN: begin
        ld_ok  = cl_ok && in_data_i.row < 3'(VEC_N);
        ld_ofs = OFS_GAIN + {3'b0, in_data_i.row};
      end
      FUNC_BIAS: begin
        ld_ok  = cl_ok && in_data_i.row < 3'(VEC_N);
        ld_ofs = OFS_BIAS + {3'b0, in_data_i.row};
      end
      FUNC_DRIVE: begin
        ld_ok  = cl_ok;
        ld_ofs = OFS_DRIVE;
      end
      FUNC_PARENT: begin
        ld_ok  = cl_ok && int'(in_data_i.parent) < MAX_CLUSTERS;
        ld_ofs = OFS_PARENT;
      end
      default: begin
        ld_ok  = 1'b0;
        ld_ofs = '0;
      end
    endcase
  end

  // memory ports and arithmetic unit requests
  always_comb begin
    p_we      = in_acc && ld_ok;
    p_waddr   = {cl_in, ld_ofs};
    p_wdata   = (func_e'(in_data_i.func) == FUNC_PARENT) ? DATA_W'(in_data_i.parent)
                                                         : in_data_i.value;
    p_raddr   = {cl_q, OFS_PARENT};
    a_we      = in_acc && func_e'(in_data_i.func) == FUNC_ROOT && in_data_i.row < 3'(VEC_N);
    a_waddr   = {CW'(0), in_data_i.row};
    a_wdata   = in_data_i.value;
    a_raddr   = {par_q, k_q};
    mul_start = 1'b0;
    mul_a     = p_rdata;
    mul_b     = a_rdata;
    div_start = 1'b0;
    div_a     = vel_q;
    div_d     = mass_q;
    case (state_q)
      S_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = clr_q;
        a_wdata = '0;
      end
      S_M_RD:  p_raddr = {cl_q, ({3'b0, k_q} * 6'd6) + {3'b0, j_q}};
      S_M_MUL: mul_start = 1'b1;
      S_D_RD:  p_raddr = {cl_q, OFS_DRIVE};
      S_G_RD:  p_raddr = {cl_q, OFS_GAIN + {3'b0, j_q}};
      S_G_MUL: begin
        mul_start = 1'b1;
        mul_b     = m_q[j_q];
      end
      S_B_RD:  p_raddr = {cl_q, OFS_BIAS + {3'b0, j_q}};
      S_B_WR: begin
        a_we    = 1'b1;
        a_waddr = {cl_q, j_q};
        a_wdata = sat48(sx(m_q[j_q]) + sx(p_rdata) + ((j_q == 3'd2) ? sx(a_q) : '0));
      end
      S_T_DIV: div_start = 1'b1;
      S_T_DW: begin
        mul_start = div_done;
        mul_a     = div_res;
        mul_b     = val_q;
      end
      S_H_G: begin
        div_start = 1'b1;
        div_a     = {1'b0, mass_q};
        div_d     = scale_q;
      end
      S_H_GW: begin
        mul_start = div_done;
        mul_a     = div_res;
        mul_b     = {1'b0, ke_q};
      end
      S_H_M1: begin
        mul_start = mul_done;
        mul_a     = g_q;
        mul_b     = {1'b0, kt_q};
      end
      S_H_M2: begin
        mul_start = mul_done;
        mul_a     = t_val;
        mul_b     = UNIT_Q;
      end
      S_H_M3: begin
        mul_start = mul_done;
        mul_a     = vel_q;
        mul_b     = vel_q;
      end
      S_H_M4: begin
        div_start = mul_done;
        div_a     = mul_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      th_on_q     <= 1'b0;
      mass_q      <= ONE_Q;
      vel_q       <= '0;
      scale_q     <= ONE_Q;
      ke_q        <= '0;
      kt_q        <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_TH_ON:    th_on_q <= cfg_data_i[0];
          REG_TH_MASS:  mass_q  <= cfg_data_i[DATA_W-2:0];
          REG_TH_VEL:   vel_q   <= cfg_data_i;
          REG_TH_SCALE: scale_q <= cfg_data_i[DATA_W-2:0];
          REG_KE:       ke_q    <= cfg_data_i[DATA_W-2:0];
          REG_KT:       kt_q    <= cfg_data_i[DATA_W-2:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AAW'(1);
          if (clr_q == AAW'(ADEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            cl_q  <= cl_in;
            val_q <= in_data_i.value;
            if (func_e'(in_data_i.func) == FUNC_RUN && cl_ok && in_data_i.cluster != '0) begin
              state_q <= S_PAR;
            end else if (func_e'(in_data_i.func) == FUNC_THERMO && th_on_q) begin
              state_q <= S_H_G;
            end
          end
        end
        S_PAR: state_q <= S_PAR_W;
        S_PAR_W: begin
          par_q <= CW'(p_rdata[5:0]);
          j_q   <= '0;
          k_q   <= '0;
          acc_q <= '0;
          state_q <= (int'(p_rdata[5:0]) < MAX_CLUSTERS) ? S_M_RD : S_IDLE;
        end
        S_M_RD:  state_q <= S_M_MUL;
        S_M_MUL: state_q <= S_M_WAIT;
        S_M_WAIT: begin
          if (mul_done) begin
            if (k_q == 3'(VEC_N - 1)) begin
              m_q[j_q] <= sat48(acc_q + sx(mul_res));
              acc_q    <= '0;
              k_q      <= '0;
              if (j_q == 3'(VEC_N - 1)) begin
                j_q     <= '0;
                state_q <= S_D_RD;
              end else begin
                j_q     <= j_q + 3'd1;
                state_q <= S_M_RD;
              end
            end else begin
              acc_q   <= acc_q + sx(mul_res);
              k_q     <= k_q + 3'd1;
              state_q <= S_M_RD;
            end
          end
        end
        S_D_RD: state_q <= S_D_W;
        S_D_W: begin
          acc_q   <= sx(p_rdata);
          state_q <= S_G_RD;
        end
        S_G_RD:  state_q <= S_G_MUL;
        S_G_MUL: state_q <= S_G_WAIT;
        S_G_WAIT: begin
          if (mul_done) begin
            if (j_q == 3'(VEC_N - 1)) begin
              a_q     <= sat48(acc_q - sx(mul_res));
              j_q     <= '0;
              state_q <= S_B_RD;
            end else begin
              acc_q   <= acc_q - sx(mul_res);
              j_q     <= j_q + 3'd1;
              state_q <= S_G_RD;
            end
          end
        end
        S_B_RD: state_q <= S_B_WR;
        S_B_WR: begin
          if (j_q == 3'(VEC_N - 1)) begin
            j_q     <= '0;
            kind_q  <= KIND_JOINT;
            state_q <= th_on_q ? S_T_DIV : S_EMIT;
          end else begin
            j_q     <= j_q + 3'd1;
            state_q <= S_B_RD;
          end
        end
        S_T_DIV: state_q <= S_T_DW;
        S_T_DW: begin
          if (div_done) state_q <= S_T_MW;
        end
        S_T_MW: begin
          if (mul_done) begin
            a_q     <= sat48(sx(a_q) - sx(mul_res));
            state_q <= S_EMIT;
          end
        end
        S_H_G: state_q <= S_H_GW;
        S_H_GW: begin
          if (div_done) begin
            g_q     <= div_res;
            state_q <= S_H_M1;
          end
        end
        S_H_M1: begin
          if (mul_done) begin
            t1_q    <= mul_res;
            state_q <= S_H_M2;
          end
        end
        S_H_M2: begin
          if (mul_done) state_q <= S_H_M3;
        end
        S_H_M3: begin
          if (mul_done) begin
            e_q     <= mul_res;
            state_q <= S_H_M4;
          end
        end
        S_H_M4: begin
          if (mul_done) state_q <= S_H_D2;
        end
        S_H_D2: begin
          if (div_done) begin
            a_q     <= sat48(sx(e_q) + sx(div_res));
            kind_q  <= KIND_THERMO;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q       <= 1'b1;
            out_q.kind        <= kind_q;
            out_q.cluster_res <= (kind_q == KIND_THERMO) ? 6'd0 : 6'(cl_q);
            out_q.value_res   <= a_q;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  abbp_ram #(.WIDTH(DATA_W), .DEPTH(PDEPTH)) u_param_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  abbp_ram #(.WIDTH(DATA_W), .DEPTH(ADEPTH)) u_accel_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  abbp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  abbp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .d_i     (div_d),
    .done_o  (div_done),
    .res_o   (div_res)
  );

endmodule

// File: hdl/abbp_checker.sv
module abbp_checker import abbp_pkg::*; #(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input in_req_t              in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input out_res_t             out_data_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_thermo_cluster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind |-> out_data_o.cluster_res == 6'd0)
    else $error("thermostat result carries a cluster");

  a_joint_cluster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.kind |-> out_data_o.cluster_res != 6'd0)
    else $error("joint result for the root cluster");

  // a run on a real cluster occupies the sequencer
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_e'(in_data_i.func) == FUNC_RUN &&
    in_data_i.cluster != 6'd0 && int'(in_data_i.cluster) < MAX_CLUSTERS |=> !in_ready_o)
    else $error("ready right after a run request");

endmodule

bind articulated_body_backward_pass abbp_checker #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import abbp_pkg::*;

  localparam int  WDOG_LIMIT = 5000;
  localparam int  N_PHASES   = 4;
  localparam int  PHASE_REQS = 260;
  localparam logic [46:0] MAX47 = {47{1'b1}};
  localparam longint UNIT_Q = ((64'd4184070 << 24) + 64'd5000) / 64'd10000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  in_req_t        in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  out_res_t       out_data_o;
  logic           cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  articulated_body_backward_pass uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic signed [47:0] xform_mem [64][36];
  logic signed [47:0] gain_mem  [64][6];
  logic signed [47:0] bias_mem  [64][6];
  logic signed [47:0] drive_mem [64];
  logic [5:0]         parent_mem[64];
  logic signed [47:0] accel_mem [64][6];
  logic               th_on;
  longint             th_mass, th_vel, th_scale, ke, kt;

  in_req_t  pend_q[$];
  out_res_t accel_exp_q[$];
  int       errors = 0;
  bit       quiet = 1'b0;
  bit       loaded[64];

  function automatic logic signed [47:0] sat48_fx(longint x);
    if (x > longint'(SMAX)) return SMAX;
    if (x < longint'(SMIN)) return SMIN;
    return x[47:0];
  endfunction

  function automatic logic signed [47:0] from_mag(bit neg, logic [127:0] m);
    if (neg) begin
      if (m > 128'h800000000000) return SMIN;
      return -$signed({1'b0, m[47:0]});
    end
    if (m > 128'h7FFFFFFFFFFF) return SMAX;
    return m[47:0];
  endfunction

  function automatic logic [127:0] mag(longint x);
    return x < 0 ? 128'(-x) : 128'(x);
  endfunction

  function automatic logic signed [47:0] qmul(longint a, longint b);
    logic [127:0] p;
    p = mag(a) * mag(b) + (128'd1 << 23);
    return from_mag((a < 0) != (b < 0), p >> 24);
  endfunction

  function automatic logic signed [47:0] qdiv(longint a, longint d);
    logic [127:0] n;
    if (a == 0) return '0;
    if (d <= 0) return a < 0 ? SMIN : SMAX;
    n = (mag(a) << 24) + 128'(d >>> 1);
    return from_mag(a < 0, n / 128'(d));
  endfunction

  task automatic predict_request(in_req_t r);
    out_res_t o;
    longint   s, a, g, t;
    logic signed [47:0] m[6];
    logic [5:0] p;
    case (func_e'(r.func))
      FUNC_THERMO: begin
        if (th_on) begin
          g = qdiv(th_mass, th_scale);
          t = sat48_fx(2 * longint'(qmul(g, ke)) - longint'(qmul(g, kt)));
          s = longint'(qmul(t, UNIT_Q)) + longint'(qdiv(qmul(th_vel, th_vel), th_mass));
          o.kind = KIND_THERMO;
          o.cluster_res = '0;
          o.value_res = sat48_fx(s);
          accel_exp_q.push_back(o);
        end
      end
      FUNC_ROOT: if (r.row < 6) accel_mem[0][r.row] = r.value;
      FUNC_TRANSFORM: if (r.row < 6 && r.col < 6) xform_mem[r.cluster][r.row*6+r.col] = r.value;
      FUNC_GAIN: if (r.row < 6) gain_mem[r.cluster][r.row] = r.value;
      FUNC_BIAS: if (r.row < 6) bias_mem[r.cluster][r.row] = r.value;
      FUNC_DRIVE: drive_mem[r.cluster] = r.value;
      FUNC_PARENT: parent_mem[r.cluster] = r.parent;
      FUNC_RUN: begin
        if (r.cluster != 0) begin
          p = parent_mem[r.cluster];
          for (int j = 0; j < 6; j++) begin
            s = 0;
            for (int k = 0; k < 6; k++)
              s += longint'(qmul(xform_mem[r.cluster][k*6+j], accel_mem[p][k]));
            m[j] = sat48_fx(s);
          end
          a = drive_mem[r.cluster];
          for (int j = 0; j < 6; j++) a -= longint'(qmul(gain_mem[r.cluster][j], m[j]));
          a = sat48_fx(a);
          for (int j = 0; j < 6; j++)
            accel_mem[r.cluster][j] = sat48_fx(longint'(m[j]) +
              longint'(bias_mem[r.cluster][j]) + (j == 2 ? a : 0));
          if (th_on) a = sat48_fx(a - longint'(qmul(qdiv(th_vel, th_mass), r.value)));
          o.kind = KIND_JOINT;
          o.cluster_res = r.cluster;
          o.value_res = a[47:0];
          accel_exp_q.push_back(o);
        end
      end
      default: ;
    endcase
  endtask

  // request driver
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_request(in_data_i);
      if (in_valid_i && !in_ready_o) begin
        // hold the pending request
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(1, 9) - 1;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pend_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    out_res_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (accel_exp_q.size() == 0) begin
          $error("unexpected result kind=%0d cluster=%0d value=%0d", out_data_o.kind,
                 out_data_o.cluster_res, out_data_o.value_res);
          errors++;
        end else begin
          e = accel_exp_q.pop_front();
          if (e.kind !== out_data_o.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_data_o.kind);
            errors++;
          end
          if (e.cluster_res !== out_data_o.cluster_res) begin
            $error("cluster_res: expected %0d, got %0d", e.cluster_res,
                   out_data_o.cluster_res);
            errors++;
          end
          if (e.value_res !== out_data_o.value_res) begin
            $error("value_res: expected %0d, got %0d", e.value_res, out_data_o.value_res);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 9) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("articulated_body_backward_pass: mismatch");
      $finish;
    end
  end

  function automatic logic signed [47:0] rand_val();
    case ($urandom_range(0, 9))
      0: return SMAX;
      1: return SMIN;
      2: return '0;
      3: return 48'({$urandom(), $urandom()});
      default: return {{22{$urandom_range(0, 1) == 1}}, 26'($urandom())};
    endcase
  endfunction

  task automatic push_req(logic [2:0] f, logic [5:0] c, logic [2:0] r, logic [2:0] k,
                          logic [5:0] p, logic signed [47:0] v);
    in_req_t q;
    q.func = f; q.cluster = c; q.row = r; q.col = k; q.parent = p; q.value = v;
    pend_q.push_back(q);
  endtask

  task automatic fill_cluster(logic [5:0] c);
    for (int i = 0; i < 36; i++)
      push_req(FUNC_TRANSFORM, c, 3'(i / 6), 3'(i % 6), 6'($urandom()), rand_val());
    for (int i = 0; i < 6; i++) begin
      push_req(FUNC_GAIN, c, 3'(i), 3'($urandom()), 6'($urandom()), rand_val());
      push_req(FUNC_BIAS, c, 3'(i), 3'($urandom()), 6'($urandom()), rand_val());
    end
    push_req(FUNC_DRIVE, c, 3'($urandom()), 3'($urandom()), 6'($urandom()), rand_val());
    push_req(FUNC_PARENT, c, 3'($urandom()), 3'($urandom()), 6'($urandom()), rand_val());
    loaded[c] = 1'b1;
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [47:0] d);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    case (idx)
      REG_TH_ON:    th_on = d[0];
      REG_TH_MASS:  th_mass = longint'(d[46:0]);
      REG_TH_VEL:   th_vel = longint'($signed(d));
      REG_TH_SCALE: th_scale = longint'(d[46:0]);
      REG_KE:       ke = longint'(d[46:0]);
      default:      kt = longint'(d[46:0]);
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || in_valid_i || accel_exp_q.size() != 0);
    // loads and ignored requests produce nothing; let the last one settle
    repeat (50) @(posedge clk_i);
  endtask

  task automatic random_phase(int n_reqs);
    int n;
    int c;
    logic [5:0] ready_list[$];
    n = 0;
    while (n < n_reqs) begin
      ready_list = {};
      for (int i = 1; i < 64; i++) if (loaded[i]) ready_list.push_back(6'(i));
      c = $urandom_range(0, 99);
      if (c < 8 || ready_list.size() == 0) begin
        fill_cluster(6'($urandom_range(1, 63)));
        n += 50;
      end else if (c < 45) begin
        push_req(FUNC_RUN, ready_list[$urandom_range(0, ready_list.size() - 1)],
                 3'($urandom()), 3'($urandom()), 6'($urandom()), rand_val());
        n++;
      end else if (c < 52) begin
        push_req(FUNC_ROOT, 6'($urandom()), 3'($urandom()), 3'($urandom()),
                 6'($urandom()), rand_val());
        n++;
      end else if (c < 60) begin
        push_req(FUNC_THERMO, 6'($urandom()), 3'($urandom()), 3'($urandom()),
                 6'($urandom()), rand_val());
        n++;
      end else if (c < 63) begin
        push_req(FUNC_RUN, '0, 3'($urandom()), 3'($urandom()), 6'($urandom()), rand_val());
        n++;
      end else begin
        // single load, row/col may be out of range and then ignored
        push_req(3'($urandom_range(0, 4)), 6'($urandom()), 3'($urandom()),
                 3'($urandom()), 6'($urandom()), rand_val());
        n++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) begin
      for (int j = 0; j < 6; j++) accel_mem[i][j] = '0;
      loaded[i] = 1'b0;
    end
    th_on = 1'b0; th_mass = 64'd1 << 24; th_vel = 0; th_scale = 64'd1 << 24;
    ke = 0; kt = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_TH_ON, 48'd0);
          cfg_write(REG_TH_MASS, 48'd1 << 24);
          cfg_write(REG_TH_VEL, 48'd0);
          cfg_write(REG_TH_SCALE, 48'd1 << 24);
          cfg_write(REG_KE, 48'd0);
          cfg_write(REG_KT, 48'd0);
          // directed: root extremes, ignored rows, a run on root, thermostat while off
          push_req(FUNC_ROOT, 6'd63, 3'd0, 3'd0, 6'd0, SMAX);
          push_req(FUNC_ROOT, 6'd5, 3'd1, 3'd7, 6'd63, SMIN);
          push_req(FUNC_ROOT, 6'd0, 3'd2, 3'd0, 6'd0, 48'sd1 << 24);
          push_req(FUNC_ROOT, 6'd0, 3'd6, 3'd0, 6'd0, SMAX);
          push_req(FUNC_ROOT, 6'd0, 3'd7, 3'd0, 6'd0, SMIN);
          push_req(FUNC_TRANSFORM, 6'd10, 3'd6, 3'd2, 6'd0, SMAX);
          push_req(FUNC_TRANSFORM, 6'd10, 3'd1, 3'd7, 6'd0, SMAX);
          push_req(FUNC_GAIN, 6'd10, 3'd7, 3'd0, 6'd0, SMIN);
          push_req(FUNC_BIAS, 6'd10, 3'd6, 3'd0, 6'd0, SMIN);
          push_req(FUNC_RUN, 6'd0, 3'd0, 3'd0, 6'd0, SMAX);
          push_req(FUNC_THERMO, 6'd0, 3'd0, 3'd0, 6'd0, 48'sd0);
          fill_cluster(6'd1);
          push_req(FUNC_PARENT, 6'd1, 3'd0, 3'd0, 6'd0, 48'sd0);
          push_req(FUNC_RUN, 6'd1, 3'd0, 3'd0, 6'd0, SMIN);
          fill_cluster(6'd63);
          push_req(FUNC_PARENT, 6'd63, 3'd0, 3'd0, 6'd1, 48'sd0);
          push_req(FUNC_RUN, 6'd63, 3'd0, 3'd0, 6'd0, SMAX);
          push_req(FUNC_PARENT, 6'd1, 3'd0, 3'd0, 6'd1, 48'sd0);
          push_req(FUNC_RUN, 6'd1, 3'd0, 3'd0, 6'd0, 48'sd0);
        end
        1: begin
          cfg_write(REG_TH_ON, 48'd1);
          cfg_write(REG_TH_MASS, 48'($urandom_range(1, 1 << 28)));
          cfg_write(REG_TH_VEL, {{20{$urandom_range(0, 1) == 1}}, 28'($urandom())});
          cfg_write(REG_TH_SCALE, 48'($urandom_range(1, 1 << 28)));
          cfg_write(REG_KE, 48'($urandom_range(0, 1 << 30)));
          cfg_write(REG_KT, 48'($urandom_range(0, 1 << 30)));
          push_req(FUNC_THERMO, 6'd0, 3'd0, 3'd0, 6'd0, 48'sd0);
        end
        2: begin
          cfg_write(REG_TH_MASS, 48'd1);
          cfg_write(REG_TH_VEL, SMIN);
          cfg_write(REG_TH_SCALE, {1'b0, MAX47});
          cfg_write(REG_KE, {1'b0, MAX47});
          cfg_write(REG_KT, 48'd0);
          push_req(FUNC_THERMO, 6'd0, 3'd0, 3'd0, 6'd0, 48'sd0);
        end
        default: begin
          quiet = 1'b1;
          cfg_write(REG_TH_MASS, {1'b0, MAX47});
          cfg_write(REG_TH_VEL, SMAX);
          cfg_write(REG_TH_SCALE, 48'd1);
          cfg_write(REG_KE, 48'd0);
          cfg_write(REG_KT, {1'b0, MAX47});
          push_req(FUNC_THERMO, 6'd0, 3'd0, 3'd0, 6'd0, 48'sd0);
        end
      endcase
      random_phase(ph == 0 ? PHASE_REQS - 130 : PHASE_REQS);
      wait_drained();
    end

    if (errors == 0) begin
      $display("articulated_body_backward_pass: match");
    end else begin
      $display("articulated_body_backward_pass: mismatch");
    end
    $finish;
  end

endmodule
